[rtl/mlp_relu_sigmoid_inference_macros.svh]
// ---------------------------------------------------------------------------
// mlp relu sigmoid inference assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef MLP_RELU_SIGMOID_INFERENCE_MACROS_SVH
`define MLP_RELU_SIGMOID_INFERENCE_MACROS_SVH

// same-cycle implication
`define MRSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mrsi_pkg.sv]
// ---------------------------------------------------------------------------
// mrsi_pkg
// shared types, constants and helpers of the mlp inference block
// ---------------------------------------------------------------------------
package mrsi_pkg;

  localparam int DEF_INPUTS        = 16;
  localparam int DEF_HIDDEN_WIDTH  = 64;
  localparam int DEF_HIDDEN_LAYERS = 3;
  localparam int DEF_OUTPUTS       = 4;
  localparam int DEF_PARAM_DEPTH   = 16384;

  localparam int PA_MAX_W    = 18;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_EMIT    = 4;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STATE = 1'b1;

  localparam logic signed [31:0] SIG_LIM = 32'sd524288;

  localparam logic [16:0] SIG_TABLE [17] = '{
    17'd22, 17'd60, 17'd162, 17'd439, 17'd1179, 17'd3108, 17'd7812, 17'd17625,
    17'd32768, 17'd47911, 17'd57724, 17'd62428, 17'd64357, 17'd65097,
    17'd65374, 17'd65476, 17'd65514
  };

  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_STORE = 2'd1,
    K_RUN   = 2'd2
  } kind_t;

  typedef struct packed {
    logic               cmd;
    logic [13:0]        param_addr;
    logic [3:0]         state_index;
    logic signed [31:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         control_index;
    logic signed [31:0] control_value;
    logic               last_control;
  } out_item_t;

  typedef struct packed {
    kind_t                kind;
    logic [PA_MAX_W-1:0]  addr;
    logic [3:0]           sidx;
    logic signed [31:0]   data;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic int clog2m(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] mul32s(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] r;
    r = 64'(a) * 64'(b);
    return r;
  endfunction

endpackage

[rtl/mrsi_front.sv]
// ---------------------------------------------------------------------------
// mrsi_front
// accepts input beats, reduces load addresses and sorts items by kind
// ---------------------------------------------------------------------------
module mrsi_front #(
  parameter int INPUTS      = mrsi_pkg::DEF_INPUTS,
  parameter int PARAM_DEPTH = mrsi_pkg::DEF_PARAM_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  mrsi_pkg::in_item_t item,
  input  mrsi_pkg::q_status_t qst,
  output logic               push,
  output mrsi_pkg::q_item_t  push_item
);
  import mrsi_pkg::*;

  localparam int MOD_STEPS = 4;

  logic [31:0] rem;
  logic        keep;
  kind_t       kind;

  // address modulo depth, quotient below sixteen
  always_comb begin
    rem = 32'(item.param_addr);
    for (int b = MOD_STEPS - 1; b >= 0; b--) begin
      if (rem >= 32'(PARAM_DEPTH << b)) rem = rem - 32'(PARAM_DEPTH << b);
    end
  end

  always_comb begin
    keep = 1'b0;
    kind = K_LOAD;
    case (item.cmd)
      CMD_LOAD: begin
        keep = 1'b1;
        kind = K_LOAD;
      end
      CMD_STATE: begin
        keep = (32'(item.state_index) < 32'(INPUTS));
        kind = (32'(item.state_index) == 32'(INPUTS - 1)) ? K_RUN : K_STORE;
      end
      default: keep = 1'b0;
    endcase
  end

  assign item_stall = qst.full;
  assign push = item_valid && !qst.full && keep;

  assign push_item.kind = kind;
  assign push_item.addr = PA_MAX_W'(rem);
  assign push_item.sidx = item.state_index;
  assign push_item.data = item.data_value;

endmodule

[rtl/mrsi_queue.sv]
// ---------------------------------------------------------------------------
// mrsi_queue
// short fifo between the front and the compute engine
// ---------------------------------------------------------------------------
module mrsi_queue #(
  parameter int DEPTH = mrsi_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mrsi_pkg::q_item_t   push_item,
  input  logic                pop,
  output logic                q_valid,
  output mrsi_pkg::q_item_t   q_item,
  output mrsi_pkg::q_status_t qst
);
  import mrsi_pkg::*;

  localparam int P_W = clog2m(DEPTH);
  localparam int C_W = $clog2(DEPTH + 1);

  q_item_t        entry [DEPTH];
  logic [P_W-1:0] wp;
  logic [P_W-1:0] rp;
  logic [C_W-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign do_push = push && (count != C_W'(DEPTH));
  assign do_pop  = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (do_push) entry[wp] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= (wp == P_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_pop) rp <= (rp == P_W'(DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + C_W'(do_push) - C_W'(do_pop);
    end
  end

  assign q_valid   = (count != '0);
  assign q_item    = entry[rp];
  assign qst.full  = (count == C_W'(DEPTH));
  assign qst.empty = (count == '0);

endmodule

[rtl/mrsi_engine.sv]
// ---------------------------------------------------------------------------
// mrsi_engine
// parameter and activation memories, mac pipeline, sigmoid and rescale
// ---------------------------------------------------------------------------
module mrsi_engine #(
  parameter int INPUTS        = mrsi_pkg::DEF_INPUTS,
  parameter int HIDDEN_WIDTH  = mrsi_pkg::DEF_HIDDEN_WIDTH,
  parameter int HIDDEN_LAYERS = mrsi_pkg::DEF_HIDDEN_LAYERS,
  parameter int OUTPUTS       = mrsi_pkg::DEF_OUTPUTS,
  parameter int PARAM_DEPTH   = mrsi_pkg::DEF_PARAM_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  mrsi_pkg::q_item_t   q_item,
  output logic                q_pop,
  input  logic signed [31:0]  out_min,
  input  logic signed [31:0]  out_max,
  output logic                out_valid,
  input  logic                out_stall,
  output mrsi_pkg::out_item_t out_item
);
  import mrsi_pkg::*;

  localparam int ACT_DEPTH = (HIDDEN_WIDTH > INPUTS) ? HIDDEN_WIDTH : INPUTS;
  localparam int AI_W      = clog2m(ACT_DEPTH);
  localparam int PA_W      = clog2m(PARAM_DEPTH);
  localparam int SI_W      = clog2m(INPUTS);
  localparam int J_W       = $clog2(ACT_DEPTH + 1);
  localparam int NODE_MAX  = (HIDDEN_WIDTH > OUTPUTS) ? HIDDEN_WIDTH : OUTPUTS;
  localparam int N_W       = clog2m(NODE_MAX);
  localparam int EMIT_N    = (OUTPUTS < MAX_EMIT) ? OUTPUTS : MAX_EMIT;
  localparam int C_W       = clog2m(EMIT_N);
  localparam int L_W       = $clog2(HIDDEN_LAYERS + 1);
  localparam int OFF_IN    = (HIDDEN_WIDTH * INPUTS) % PARAM_DEPTH;
  localparam int OFF_HID   = (HIDDEN_WIDTH * HIDDEN_WIDTH) % PARAM_DEPTH;
  localparam int OFF_OUT   = (OUTPUTS * HIDDEN_WIDTH) % PARAM_DEPTH;
  localparam int W0        = (2 * INPUTS) % PARAM_DEPTH;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_N_RD  = 11'b00000000010,
    S_N_D   = 11'b00000000100,
    S_N_M   = 11'b00000001000,
    S_N_WR  = 11'b00000010000,
    S_L_SET = 11'b00000100000,
    S_L_RUN = 11'b00001000000,
    S_L_DRN = 11'b00010000000,
    S_G_A   = 11'b00100000000,
    S_G_B   = 11'b01000000000,
    S_G_C   = 11'b10000000000
  } st_t;

  // memories
  logic [31:0]        pmem [PARAM_DEPTH];
  logic [31:0]        sbuf [INPUTS];
  logic [31:0]        actm [2 * ACT_DEPTH];
  logic signed [31:0] pm_q;
  logic signed [31:0] sb_q;
  logic signed [31:0] act_q;

  st_t                st;
  logic [SI_W-1:0]    k;
  logic [L_W-1:0]     lay;
  logic [PA_W-1:0]    wptr;
  logic [PA_W-1:0]    bptr;
  logic [J_W-1:0]     j;
  logic [N_W-1:0]     node;
  logic               v1, b1, v2, b2;
  logic [N_W-1:0]     n1, n2;
  logic signed [31:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] d_r;
  logic signed [31:0] ctrl [EMIT_N];
  logic [C_W-1:0]     e;
  logic [16:0]        lo_r;
  logic [32:0]        ip;
  logic signed [63:0] scale;

  logic                pm_we;
  logic [PA_W-1:0]     pm_ra;
  logic                act_we;
  logic [AI_W:0]       act_wa;
  logic signed [31:0]  act_wd;
  logic [AI_W:0]       act_ra;
  logic                is_out;
  logic [J_W-1:0]      nin;
  logic [N_W-1:0]      nout_m1;
  logic [PA_W:0]       off;
  logic [PA_W:0]       bsum;
  logic                bias_beat;
  logic signed [31:0]  res;
  logic signed [31:0]  res_act;
  logic signed [31:0]  xin;
  logic [31:0]         u;
  logic [4:0]          seg;
  logic [16:0]         lo_c;
  logic [16:0]         diff;
  logic [17:0]         s_val;
  logic signed [32:0]  rng;
  logic signed [31:0]  v_out;
  logic                slot_free;

  function automatic logic [PA_W-1:0] inc_ptr(input logic [PA_W-1:0] p);
    return (p == PA_W'(PARAM_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign is_out    = (lay == L_W'(HIDDEN_LAYERS));
  assign nin       = (lay == '0) ? J_W'(INPUTS) : J_W'(HIDDEN_WIDTH);
  assign nout_m1   = is_out ? N_W'(OUTPUTS - 1) : N_W'(HIDDEN_WIDTH - 1);
  assign off       = (lay == '0) ? (PA_W+1)'(OFF_IN) :
                     (is_out ? (PA_W+1)'(OFF_OUT) : (PA_W+1)'(OFF_HID));
  assign bsum      = {1'b0, wptr} + off;
  assign bias_beat = (j == nin);

  assign pm_we = (st == S_IDLE) && q_valid && (q_item.kind == K_LOAD);
  assign q_pop = (st == S_IDLE) && q_valid;

  always_comb begin
    case (st)
      S_N_RD:  pm_ra = PA_W'(k);
      S_N_D:   pm_ra = PA_W'(INPUTS) + PA_W'(k);
      S_L_RUN: pm_ra = bias_beat ? bptr : wptr;
      default: pm_ra = '0;
    endcase
  end

  assign act_ra = {lay[0], AI_W'(j)};

  // accumulate stage
  assign res     = sat32(64'(acc) + (prod >>> 16));
  assign res_act = (!is_out && res < 0) ? 32'sd0 : res;

  always_comb begin
    act_we = 1'b0;
    act_wa = {~lay[0], AI_W'(n2)};
    act_wd = res_act;
    if (st == S_N_WR) begin
      act_we = 1'b1;
      act_wa = {1'b0, AI_W'(k)};
      act_wd = sat32(prod >>> 16);
    end else if (v2 && b2 && !is_out) begin
      act_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) pmem[PA_W'(q_item.addr)] <= q_item.data;
    pm_q <= pmem[pm_ra];
  end

  always_ff @(posedge clk) begin
    if ((st == S_IDLE) && q_valid && (q_item.kind != K_LOAD)) begin
      sbuf[SI_W'(q_item.sidx)] <= q_item.data;
    end
    sb_q <= sbuf[k];
  end

  always_ff @(posedge clk) begin
    if (act_we) actm[act_wa] <= act_wd;
    act_q <= actm[act_ra];
  end

  // sigmoid interpolation inputs
  always_comb begin
    xin   = ctrl[e];
    u     = xin + SIG_LIM;
    seg   = {1'b0, u[19:16]};
    lo_c  = SIG_TABLE[seg];
    diff  = SIG_TABLE[seg + 5'd1] - lo_c;
    s_val = 18'(lo_r) + 18'(ip[31:16]);
    rng   = 33'(out_max) - 33'(out_min);
    v_out = sat32(64'(out_min) + (scale >>> 16));
  end

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    // pipeline payload
    b1 <= bias_beat;
    n1 <= node;
    b2 <= b1;
    n2 <= n1;
    if (v1) prod <= b1 ? (64'(pm_q) <<< 16) : mul32s(pm_q, act_q);
    if (v2) acc <= b2 ? 32'sd0 : res;
    if (v2 && b2 && is_out && int'(n2) < EMIT_N) ctrl[C_W'(n2)] <= res;

    case (st)
      S_N_D:  d_r <= sat32(64'(sb_q) - 64'(pm_q));
      S_N_M:  prod <= mul32s(d_r, pm_q);
      S_L_SET: acc <= 32'sd0;
      S_G_A: begin
        if (xin >= SIG_LIM) begin
          lo_r <= SIG_TABLE[16];
          ip   <= '0;
        end else if (xin <= -SIG_LIM) begin
          lo_r <= SIG_TABLE[0];
          ip   <= '0;
        end else begin
          lo_r <= lo_c;
          ip   <= 33'(diff) * 33'(u[15:0]);
        end
      end
      S_G_B: scale <= 64'($signed({1'b0, s_val})) * 64'(rng);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      k    <= '0;
      lay  <= '0;
      wptr <= '0;
      bptr <= '0;
      j    <= '0;
      node <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      e    <= '0;
    end else begin
      v1 <= (st == S_L_RUN);
      v2 <= v1;
      case (st)
        S_IDLE: begin
          if (q_valid && q_item.kind == K_RUN) begin
            k  <= '0;
            st <= S_N_RD;
          end
        end
        S_N_RD: st <= S_N_D;
        S_N_D:  st <= S_N_M;
        S_N_M:  st <= S_N_WR;
        S_N_WR: begin
          if (k == SI_W'(INPUTS - 1)) begin
            wptr <= PA_W'(W0);
            lay  <= '0;
            st   <= S_L_SET;
          end else begin
            k  <= k + 1'b1;
            st <= S_N_RD;
          end
        end
        S_L_SET: begin
          j    <= '0;
          node <= '0;
          bptr <= (bsum >= (PA_W+1)'(PARAM_DEPTH)) ?
                  PA_W'(bsum - (PA_W+1)'(PARAM_DEPTH)) : PA_W'(bsum);
          st   <= S_L_RUN;
        end
        S_L_RUN: begin
          if (bias_beat) begin
            bptr <= inc_ptr(bptr);
            j    <= '0;
            if (node == nout_m1) st <= S_L_DRN;
            else node <= node + 1'b1;
          end else begin
            wptr <= inc_ptr(wptr);
            j    <= j + 1'b1;
          end
        end
        S_L_DRN: begin
          if (!v1 && !v2) begin
            if (is_out) begin
              e  <= '0;
              st <= S_G_A;
            end else begin
              lay  <= lay + 1'b1;
              wptr <= bptr;
              st   <= S_L_SET;
            end
          end
        end
        S_G_A: st <= S_G_B;
        S_G_B: st <= S_G_C;
        S_G_C: begin
          if (slot_free) begin
            if (e == C_W'(EMIT_N - 1)) begin
              st <= S_IDLE;
            end else begin
              e  <= e + 1'b1;
              st <= S_G_A;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == S_G_C && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_G_C && slot_free) begin
      out_item.control_index <= 2'(e);
      out_item.control_value <= v_out;
      out_item.last_control  <= (e == C_W'(EMIT_N - 1));
    end
  end

endmodule

[rtl/mlp_relu_sigmoid_inference.sv]
// ---------------------------------------------------------------------------
// mlp_relu_sigmoid_inference
// q16.16 multilayer perceptron with relu hidden layers and sigmoid outputs
// ---------------------------------------------------------------------------
// load beats (cmd 0) write one word of the parameter memory, and state
// beats (cmd 1) store one input sample; the beat carrying the highest input
// index starts an inference. the inference runs on a single
// multiply-accumulate pipeline fed by one read port of the parameter
// memory: normalization reads, subtracts, multiplies and writes back each
// input in turn, a layer streams nin weights and one bias per output node
// and then drains the pipeline, and each emitted control passes through
// interpolation, a rescale multiply and the wait for a free output slot.
// a two entry queue lets the input side take beats while the engine is
// busy, and an output register holds a finished control while the engine
// moves on. out_min and out_max must be written only while the block is
// idle. the parameter memory has no reset and must be loaded before inference.
module mlp_relu_sigmoid_inference #(
  parameter int INPUTS        = mrsi_pkg::DEF_INPUTS,
  parameter int HIDDEN_WIDTH  = mrsi_pkg::DEF_HIDDEN_WIDTH,
  parameter int HIDDEN_LAYERS = mrsi_pkg::DEF_HIDDEN_LAYERS,
  parameter int OUTPUTS       = mrsi_pkg::DEF_OUTPUTS,
  parameter int PARAM_DEPTH   = mrsi_pkg::DEF_PARAM_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  mrsi_pkg::in_item_t                   item,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output mrsi_pkg::out_item_t                  result,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [mrsi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_wdata
);
  import mrsi_pkg::*;
  `include "mlp_relu_sigmoid_inference_macros.svh"

  localparam int EMIT_N = (OUTPUTS < MAX_EMIT) ? OUTPUTS : MAX_EMIT;
  localparam logic [1:0] LAST_IDX = 2'(EMIT_N - 1);

  // control range registers
  logic signed [31:0] out_min;
  logic signed [31:0] out_max;

  // front to queue
  logic      push;
  q_item_t   push_item;
  q_status_t qst;

  // queue to engine
  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_min <= 32'sd0;
      out_max <= 32'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUT_MIN: out_min <= cfg_wdata;
        REG_OUT_MAX: out_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // classify beats; out-of-range state beats are taken and dropped
  mrsi_front #(
    .INPUTS      (INPUTS),
    .PARAM_DEPTH (PARAM_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .qst        (qst),
    .push       (push),
    .push_item  (push_item)
  );

  // decouples the input side from the engine
  mrsi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .qst       (qst)
  );

  // memories, mac pipeline, sigmoid and output register
  mrsi_engine #(
    .INPUTS        (INPUTS),
    .HIDDEN_WIDTH  (HIDDEN_WIDTH),
    .HIDDEN_LAYERS (HIDDEN_LAYERS),
    .OUTPUTS       (OUTPUTS),
    .PARAM_DEPTH   (PARAM_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_min   (out_min),
    .out_max   (out_max),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_item  (result)
  );

  // the final control of a run carries the last index, others do not
  `MRSI_ASSERT_IMP(a_last_idx, result_valid && result.last_control, result.control_index == LAST_IDX, "last control with wrong index")
  `MRSI_ASSERT_IMP(a_mid_idx, result_valid && !result.last_control, result.control_index != LAST_IDX, "non-final control with last index")
  // input stall is exactly a full queue
  `MRSI_ASSERT_IMP(a_stall_full, 1'b1, item_stall == qst.full, "input stall does not track queue")
  // a run cannot produce another control right after its last one
  `MRSI_ASSERT_NXT(a_run_end, result_valid && !result_stall && result.last_control, !result_valid, "result right after final control")

endmodule
